@@ sv/dtdr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtdr_pkg
// Shared types and constants for the divider timer with delayed reload.
// ----------------------------------------------------------------------------
package dtdr_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SEL_DIVIDER = 2'd0,
    SEL_COUNTER = 2'd1,
    SEL_RELOAD  = 2'd2,
    SEL_CONTROL = 2'd3
  } sel_t;

  localparam int unsigned TAP_COUNT = 4;

  typedef logic [3:0] tap_t;
  typedef tap_t       tap_table_t [TAP_COUNT];

  localparam tap_t TAP_RESET_0 = 4'd9;
  localparam tap_t TAP_RESET_1 = 4'd3;
  localparam tap_t TAP_RESET_2 = 4'd5;
  localparam tap_t TAP_RESET_3 = 4'd7;

  localparam logic [7:0]  CTRL_READ_FILL = 8'hF8;
  localparam logic [15:0] DIV_STEP       = 16'h0004;
  localparam int unsigned ENABLE_BIT     = 2;

  typedef struct packed {
    op_t        operation;
    sel_t       reg_select;
    logic [7:0] write_data;
  } item_t;

endpackage
`default_nettype wire

@@ sv/divider_timer_with_delayed_reload.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// divider_timer_with_delayed_reload
// Divider, counter, reload and control registers of a machine-cycle timer.
// ----------------------------------------------------------------------------
// One transaction per clock while result_stall stays low: each tick, read
// or write enters an input register and is executed when the result register
// can take it; the state update (divider add, tap select, counter increment)
// then writes the result register, and result_valid rises. The user must
// write the tap bit registers through cfg_write_enable / cfg_index / cfg_data
// only while no transaction is in flight; the block does not enforce this.
module divider_timer_with_delayed_reload
  import dtdr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_enable,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_data,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [1:0] operation,
  input  wire logic [1:0] reg_select,
  input  wire logic [7:0] write_data,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [7:0]      read_data,
  output logic            interrupt_request
);

  tap_table_t  taps;
  logic [15:0] divider, divider_next;
  logic [7:0]  counter, counter_next;
  logic [7:0]  reload_value, reload_value_next;
  logic [2:0]  control, control_next;
  logic        overflow_wait, overflow_wait_next;
  logic        reload_pending, reload_pending_next;

  item_t       in_item;
  logic        in_full;
  logic        out_full;
  logic [7:0]  read_data_next;
  logic        irq_next;
  logic        advance;

  assign advance      = in_full && (!out_full || !result_stall);
  assign item_stall   = in_full && !advance;
  assign result_valid = out_full;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!item_stall) begin
      in_full <= item_valid;
    end
    if (!item_stall && item_valid) begin
      in_item <= '{operation: op_t'(operation), reg_select: sel_t'(reg_select),
                   write_data: write_data};
    end
  end

  // tap bit configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      taps[0] <= TAP_RESET_0;
      taps[1] <= TAP_RESET_1;
      taps[2] <= TAP_RESET_2;
      taps[3] <= TAP_RESET_3;
    end else if (cfg_write_enable) begin
      taps[cfg_index] <= cfg_data;
    end
  end

  // execute one transaction against the timer state
  logic       enabled;
  logic       watched_old;
  logic [7:0] bump_base;
  logic       bump;
  logic [7:0] bumped;
  tap_t       new_tap;

  always_comb begin
    divider_next        = divider;
    counter_next        = counter;
    reload_value_next   = reload_value;
    control_next        = control;
    overflow_wait_next  = overflow_wait;
    reload_pending_next = reload_pending;
    read_data_next      = 8'h00;
    irq_next            = 1'b0;
    enabled             = control[ENABLE_BIT];
    watched_old         = divider[taps[control[1:0]]];
    new_tap             = taps[in_item.write_data[1:0]];
    bump_base           = counter;
    bump                = 1'b0;

    unique case (in_item.operation)
      OP_TICK: begin
        divider_next = divider + DIV_STEP;
        if (overflow_wait) begin
          overflow_wait_next  = 1'b0;
          reload_pending_next = 1'b1;
        end else if (reload_pending) begin
          reload_pending_next = 1'b0;
          bump_base           = reload_value;
          counter_next        = reload_value;
          irq_next            = 1'b1;
        end
        bump = enabled && watched_old && !divider_next[taps[control[1:0]]];
      end
      OP_READ: begin
        unique case (in_item.reg_select)
          SEL_DIVIDER: read_data_next = divider[15:8];
          SEL_COUNTER: read_data_next = counter;
          SEL_RELOAD:  read_data_next = reload_value;
          SEL_CONTROL: read_data_next = {5'd0, control} | CTRL_READ_FILL;
          default:     read_data_next = 8'h00;
        endcase
      end
      OP_WRITE: begin
        unique case (in_item.reg_select)
          SEL_DIVIDER: begin
            divider_next = 16'h0000;
            bump         = enabled && watched_old;
          end
          SEL_COUNTER: begin
            // ignored while the reload is being applied
            if (!reload_pending) begin
              counter_next       = in_item.write_data;
              overflow_wait_next = 1'b0;
            end
          end
          SEL_RELOAD: reload_value_next = in_item.write_data;
          SEL_CONTROL: begin
            control_next = in_item.write_data[2:0];
            // false edge when the gated tap falls
            bump = enabled && watched_old
                   && !(in_item.write_data[ENABLE_BIT] && divider[new_tap]);
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    bumped = bump_base + 8'd1;
    if (bump) begin
      counter_next = bumped;
      if (bumped == 8'h00) begin
        overflow_wait_next = 1'b1;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      divider        <= 16'h0000;
      counter        <= 8'h00;
      reload_value   <= 8'h00;
      control        <= 3'd0;
      overflow_wait  <= 1'b0;
      reload_pending <= 1'b0;
      out_full       <= 1'b0;
    end else begin
      if (advance) begin
        divider        <= divider_next;
        counter        <= counter_next;
        reload_value   <= reload_value_next;
        control        <= control_next;
        overflow_wait  <= overflow_wait_next;
        reload_pending <= reload_pending_next;
        out_full       <= 1'b1;
      end else if (!result_stall) begin
        out_full <= 1'b0;
      end
    end
    if (advance) begin
      read_data         <= read_data_next;
      interrupt_request <= irq_next;
    end
  end

`ifndef SYNTHESIS
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(read_data) && $stable(interrupt_request)))
    else $error("stalled result changed");

  a_irq_no_read_data: assert property (@(posedge clk) disable iff (rst)
    (result_valid && interrupt_request) |-> (read_data == 8'h00))
    else $error("interrupt result carries read data");

  a_irq_after_pending: assert property (@(posedge clk) disable iff (rst)
    (advance && irq_next) |=> !reload_pending)
    else $error("reload left the pending flag set");
`endif

endmodule
`default_nettype wire
